>>> hdl/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants of the running median block
// Payload structs, heap select codes, control/status structs and the
// heap ordering function.
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned MEDIAN_W     = 33;
  localparam int unsigned COUNT_OUT_W  = 11;

  // heap select codes
  localparam logic HEAP_LOWER = 1'b0;
  localparam logic HEAP_UPPER = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_of_stream;
  } in_t;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0]  median_twice;
    logic                        dropped;
    logic [COUNT_OUT_W-1:0]      sample_count;
  } out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic decide;
    logic start_sd;
    logic start_su;
    logic su_carry;
    logic sel;
    logic rd;
    logic rd_up;
    logic sd_step;
    logic su_step;
    logic inc;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic even;
    logic swap;
    logic sel;
    logic sd_done;
    logic su_done;
  } sts_t;

  // true if a belongs above b (max-heap for the lower half)
  function automatic logic above(logic signed [SAMPLE_W-1:0] a,
                                 logic signed [SAMPLE_W-1:0] b,
                                 logic is_max);
    logic res;
    res = is_max ? (a > b) : (a < b);
    return res;
  endfunction

endpackage

>>> hdl/rmth_dp.sv
// ----------------------------------------------------------------------------
// rmth_dp: heap datapath
// Two heap memories, root copies, counts, sift position and output register.
// ----------------------------------------------------------------------------
module rmth_dp #(
  parameter int unsigned CAPACITY = rmth_pkg::CAPACITY_DEF,
  parameter int unsigned HALF     = (CAPACITY + 1) / 2,
  parameter int unsigned AW       = (HALF > 1) ? $clog2(HALF) : 1,
  parameter int unsigned CW       = $clog2(HALF + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rmth_pkg::cmd_t cmd_i,
  output rmth_pkg::sts_t sts_o,
  input  rmth_pkg::in_t  in_data_i,
  output rmth_pkg::out_t out_data_o
);

  localparam int unsigned LW = AW + 2;
  localparam int unsigned TW = CW + 1;

  logic signed [31:0] lower_mem [HALF];
  logic signed [31:0] upper_mem [HALF];

  logic signed [31:0] x_q, val_q, carry_q, lroot_q, uroot_q;
  logic signed [31:0] la_q, lb_q, ua_q, ub_q;
  logic [CW-1:0]      lc_q, uc_q;
  logic [AW-1:0]      pos_q;
  logic               sel_q, drop_q;
  rmth_pkg::out_t     out_q;

  logic [TW-1:0]      total;
  logic [CW-1:0]      cnt_sel, cnt_cmd;
  logic [LW-1:0]      l_w, r_w, n_w;
  logic [AW-1:0]      pm1, parent, rd_a, rd_b;
  logic signed [31:0] da, db, root_cmd;
  logic               is_max, lv, rv, best_l, best_r, sd_done, su_done;
  logic signed [31:0] bv1;
  logic               we;
  logic signed [31:0] wd;
  logic [AW-1:0]      pos_step;

  // status
  assign total   = {1'b0, lc_q} + {1'b0, uc_q};
  assign cnt_sel = (sel_q == rmth_pkg::HEAP_LOWER) ? lc_q : uc_q;
  assign cnt_cmd = (cmd_i.sel == rmth_pkg::HEAP_LOWER) ? lc_q : uc_q;
  assign root_cmd = (cmd_i.sel == rmth_pkg::HEAP_LOWER) ? lroot_q : uroot_q;

  assign sts_o.full = (total >= TW'(CAPACITY));
  assign sts_o.even = (lc_q == uc_q);
  assign sts_o.swap = (lc_q == uc_q) ? ((uc_q != '0) && (x_q > uroot_q))
                                     : (x_q < lroot_q);
  assign sts_o.sel  = sel_q;

  // child and parent addresses
  assign l_w    = {1'b0, pos_q, 1'b1};
  assign r_w    = l_w + LW'(1);
  assign n_w    = LW'(cnt_sel);
  assign pm1    = pos_q - AW'(1);
  assign parent = pm1 >> 1;
  assign rd_a   = cmd_i.rd_up ? parent : l_w[AW-1:0];
  assign rd_b   = r_w[AW-1:0];

  // compare step
  assign is_max  = (sel_q == rmth_pkg::HEAP_LOWER);
  assign da      = (sel_q == rmth_pkg::HEAP_LOWER) ? la_q : ua_q;
  assign db      = (sel_q == rmth_pkg::HEAP_LOWER) ? lb_q : ub_q;
  assign lv      = (l_w < n_w);
  assign rv      = (r_w < n_w);
  assign best_l  = lv && rmth_pkg::above(da, val_q, is_max);
  assign bv1     = best_l ? da : val_q;
  assign best_r  = rv && rmth_pkg::above(db, bv1, is_max);
  assign sd_done = !best_l && !best_r;
  assign su_done = (pos_q == '0) || !rmth_pkg::above(val_q, da, is_max);
  assign sts_o.sd_done = sd_done;
  assign sts_o.su_done = su_done;

  always_comb begin
    we       = 1'b0;
    wd       = val_q;
    pos_step = pos_q;
    if (cmd_i.sd_step) begin
      we = 1'b1;
      if (sd_done) begin
        wd = val_q;
      end else if (best_r) begin
        wd       = db;
        pos_step = r_w[AW-1:0];
      end else begin
        wd       = da;
        pos_step = l_w[AW-1:0];
      end
    end else if (cmd_i.su_step) begin
      we = 1'b1;
      if (su_done) begin
        wd = val_q;
      end else begin
        wd       = da;
        pos_step = parent;
      end
    end
  end

  // heap memories
  always_ff @(posedge clk_i) begin
    if (we && sel_q == rmth_pkg::HEAP_LOWER) begin
      lower_mem[pos_q] <= wd;
    end
    if (we && sel_q == rmth_pkg::HEAP_UPPER) begin
      upper_mem[pos_q] <= wd;
    end
    if (cmd_i.rd) begin
      la_q <= lower_mem[rd_a];
      lb_q <= lower_mem[rd_b];
      ua_q <= upper_mem[rd_a];
      ub_q <= upper_mem[rd_b];
    end
  end

  // counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= '0;
      uc_q <= '0;
    end else if (cmd_i.load && in_data_i.start_of_stream) begin
      lc_q <= '0;
      uc_q <= '0;
    end else if (cmd_i.inc) begin
      if (sel_q == rmth_pkg::HEAP_LOWER) begin
        lc_q <= lc_q + CW'(1);
      end else begin
        uc_q <= uc_q + CW'(1);
      end
    end
  end

  // working registers and root copies
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= in_data_i.sample;
    end
    if (cmd_i.decide) begin
      drop_q <= sts_o.full;
    end
    if (we && pos_q == '0) begin
      if (sel_q == rmth_pkg::HEAP_LOWER) begin
        lroot_q <= wd;
      end else begin
        uroot_q <= wd;
      end
    end
    if (cmd_i.start_sd) begin
      sel_q   <= cmd_i.sel;
      pos_q   <= '0;
      val_q   <= x_q;
      carry_q <= root_cmd;
    end else if (cmd_i.start_su) begin
      sel_q <= cmd_i.sel;
      pos_q <= AW'(cnt_cmd);
      val_q <= cmd_i.su_carry ? carry_q : x_q;
    end else begin
      pos_q <= pos_step;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (total == '0) begin
        out_q.median_twice <= '0;
      end else if (lc_q > uc_q) begin
        out_q.median_twice <= {lroot_q, 1'b0};
      end else begin
        out_q.median_twice <= {lroot_q[31], lroot_q} + {uroot_q[31], uroot_q};
      end
      out_q.dropped      <= drop_q;
      out_q.sample_count <= rmth_pkg::COUNT_OUT_W'(total);
    end
  end

  assign out_data_o = out_q;

endmodule

>>> hdl/rmth_ctrl.sv
// ----------------------------------------------------------------------------
// rmth_ctrl: sequencer for insert, sift and rebalance
// Walks each item through decide, optional sift down and sift up, and result.
// ----------------------------------------------------------------------------
module rmth_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  rmth_pkg::sts_t sts_i,
  output rmth_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_SD_RD, S_SD_CMP, S_SU_RD, S_SU_CMP, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.full) begin
          state_d = S_FINISH;
        end else if (sts_i.swap) begin
          cmd_o.start_sd = 1'b1;
          cmd_o.sel      = sts_i.even ? rmth_pkg::HEAP_UPPER : rmth_pkg::HEAP_LOWER;
          state_d        = S_SD_RD;
        end else begin
          cmd_o.start_su = 1'b1;
          cmd_o.sel      = sts_i.even ? rmth_pkg::HEAP_LOWER : rmth_pkg::HEAP_UPPER;
          state_d        = S_SU_RD;
        end
      end
      S_SD_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd_o.sd_step = 1'b1;
        if (sts_i.sd_done) begin
          // old root moves to the other heap
          cmd_o.start_su = 1'b1;
          cmd_o.su_carry = 1'b1;
          cmd_o.sel      = ~sts_i.sel;
          state_d        = S_SU_RD;
        end else begin
          state_d = S_SD_RD;
        end
      end
      S_SU_RD: begin
        cmd_o.rd    = 1'b1;
        cmd_o.rd_up = 1'b1;
        state_d     = S_SU_CMP;
      end
      S_SU_CMP: begin
        cmd_o.su_step = 1'b1;
        if (sts_i.su_done) begin
          cmd_o.inc = 1'b1;
          state_d   = S_FINISH;
        end else begin
          state_d = S_SU_RD;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps: running median over a signed sample stream
// Lower half in a max-heap, upper half in a min-heap, twice the median out.
// ----------------------------------------------------------------------------
// One transaction at a time. Each item passes accept, decide and result,
// plus one registered memory read and one compare/write per heap level
// walked. A plain insert sifts up through u parent moves; an insert that
// first replaces a root also sifts down through d levels before that. With
// CAPACITY 1024 (512 per heap) a sift down or a sift up walks at most 9 levels.
// A dropped sample (storage full) skips both sifts. The result register lets
// the next sample enter while a result still waits. No clearing pass is run.
module running_median_two_heaps #(
  parameter int unsigned CAPACITY = rmth_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rmth_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rmth_pkg::out_t out_data_o
);

  rmth_pkg::cmd_t cmd;
  rmth_pkg::sts_t sts;

  // sequencer
  rmth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // heaps and arithmetic
  rmth_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> hdl/rmth_checker.sv
// ----------------------------------------------------------------------------
// rmth_checker: port-level checks of the running median block
// Watches the handshakes and result fields over time.
// ----------------------------------------------------------------------------
module rmth_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rmth_pkg::out_t out_data_o
);

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // one transaction in flight: input stalls right after acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second sample taken while busy");

  // every result holds at least one sample
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.sample_count != '0)
    else $error("empty result");

  // a drop only happens with more than one sample held
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dropped |-> out_data_o.sample_count != 11'd1)
    else $error("drop reported with one sample held");

endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
